// ===== rtl/core/nrra_pkg.sv =====
// Shared types and constants for the named region registry allocator.
// No dependencies; imported by every module of the block.
`default_nettype none

package nrra_pkg;

    localparam int          NRRA_MAX_ENTRIES_DEF = 16;
    localparam int          NRRA_QUEUE_DEPTH     = 2;
    localparam logic [63:0] NRRA_HASH_SEED       = 64'd5381;
    localparam logic [31:0] NRRA_DEVICE_RESET    = 32'h0200_0000;
    localparam logic [15:0] NRRA_HEADER_RESET    = 16'h0000;
    localparam int          NRRA_CFG_IDX_W       = 2;

    localparam logic [NRRA_CFG_IDX_W-1:0] REG_DEVICE_BYTES = 2'd0;
    localparam logic [NRRA_CFG_IDX_W-1:0] REG_HEADER_BYTES = 2'd1;

    typedef enum logic [1:0] {
        ST_NEW     = 2'd0,
        ST_KNOWN   = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOSPACE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LOOK,
        BK_CMP,
        BK_DECIDE
    } back_state_t;

    // One completed name, handed from the front to the back.
    typedef struct packed {
        logic [63:0] hash;
        logic [63:0] phys_address;
        logic [31:0] region_bytes;
    } job_t;

    // Queue handshake seen by the back end.
    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage : nrra_pkg

`default_nettype wire

// ===== rtl/core/nrra_front.sv =====
// Front end: accepts name bytes, folds them into the djb2 hash and
// emits one job per completed name. Depends on nrra_pkg.
`default_nettype none

module nrra_front
    import nrra_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [7:0]  name_byte,
    input  wire logic        name_last,
    input  wire logic [63:0] phys_address,
    input  wire logic [31:0] region_bytes,
    output logic             push,
    output job_t             push_job
);

    logic [63:0] hash_reg;
    logic [63:0] hash_next;
    logic [63:0] hash_fold;

    // hash * 33 + byte, modulo 2^64
    assign hash_fold = (hash_reg << 5) + hash_reg + {56'd0, name_byte};

    always_comb
    begin
        hash_next = hash_reg;
        if (accept)
        begin
            hash_next = name_last ? NRRA_HASH_SEED : hash_fold;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= NRRA_HASH_SEED;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

    assign push                  = accept && name_last;
    assign push_job.hash         = hash_fold;
    assign push_job.phys_address = phys_address;
    assign push_job.region_bytes = region_bytes;

endmodule : nrra_front

`default_nettype wire

// ===== rtl/core/nrra_queue.sv =====
// Short job queue between the front and back ends.
// Depends on nrra_pkg for the job type and depth.
`default_nettype none

module nrra_queue
    import nrra_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire job_t    push_job,
    input  wire logic    pop,
    output job_t         head_job,
    output queue_status_t qstat
);

    localparam int PW = (NRRA_QUEUE_DEPTH > 1) ? $clog2(NRRA_QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(NRRA_QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(NRRA_QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(NRRA_QUEUE_DEPTH);

    job_t          slot_reg [NRRA_QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          do_push;
    logic          do_pop;

    assign qstat.empty = (cnt_reg == '0);
    assign qstat.full  = (cnt_reg == DEPTH_C);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head_job    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_push_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        !(push && qstat.full))
        else $error("job pushed into a full queue");

    a_no_pop_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && qstat.empty))
        else $error("job popped from an empty queue");

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH_C)
        else $error("queue count past depth");

endmodule : nrra_queue

`default_nettype wire

// ===== rtl/core/nrra_back.sv =====
// Back end: walks the entry table for a duplicate hash, checks count and
// space, records new entries and drives the result. Depends on nrra_pkg.
`default_nettype none

module nrra_back
    import nrra_pkg::*;
#(
    parameter int MAX_ENTRIES = NRRA_MAX_ENTRIES_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire job_t          head_job,
    input  wire queue_status_t qstat,
    output logic               pop,
    input  wire logic [31:0]   device_bytes,
    input  wire logic [15:0]   header_bytes,
    output logic               done,
    output logic [1:0]         status,
    output logic [31:0]        region_offset,
    output logic [63:0]        name_hash
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);

    // Entry store, one write or one read port per cycle
    logic [63:0] hash_mem   [MAX_ENTRIES];
    logic [63:0] phys_mem   [MAX_ENTRIES];
    logic [31:0] size_mem   [MAX_ENTRIES];
    logic [31:0] offset_mem [MAX_ENTRIES];

    back_state_t   state_reg;
    back_state_t   state_next;
    job_t          job_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [32:0]   used_reg;
    logic [32:0]   used_next;
    logic          found_reg;
    logic          found_next;
    logic [63:0]   rdata_reg;
    logic          done_reg;
    status_t       status_reg;
    logic [31:0]   offset_reg;
    logic [63:0]   hash_out_reg;

    logic          rd_en;
    logic          wr_en;
    logic          decide;
    logic          match;
    logic          table_full;
    logic          no_space;
    logic [33:0]   space_sum;
    logic [33:0]   base;
    status_t       status_calc;

    assign match      = (rdata_reg == job_reg.hash);
    assign table_full = (count_reg == MAX_C);
    assign base       = 34'(header_bytes) + 34'(used_reg);
    assign space_sum  = base + 34'(job_reg.region_bytes);
    assign no_space   = space_sum > 34'(device_bytes);

    always_comb
    begin
        if (found_reg)
        begin
            status_calc = ST_KNOWN;
        end
        else if (table_full)
        begin
            status_calc = ST_FULL;
        end
        else if (no_space)
        begin
            status_calc = ST_NOSPACE;
        end
        else
        begin
            status_calc = ST_NEW;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!qstat.empty)
                begin
                    state_next = BK_LOOK;
                end
            end
            BK_LOOK:
            begin
                state_next = (idx_reg == count_reg) ? BK_DECIDE : BK_CMP;
            end
            BK_CMP:
            begin
                state_next = match ? BK_DECIDE : BK_LOOK;
            end
            BK_DECIDE:
            begin
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        pop    = 1'b0;
        rd_en  = 1'b0;
        decide = 1'b0;
        unique case (state_reg)
            BK_IDLE:   pop    = !qstat.empty;
            BK_LOOK:   rd_en  = (idx_reg != count_reg);
            BK_CMP:    ;
            BK_DECIDE: decide = 1'b1;
            default:   ;
        endcase
    end

    assign wr_en = decide && (status_calc == ST_NEW);

    always_comb
    begin
        idx_next   = idx_reg;
        found_next = found_reg;
        count_next = count_reg;
        used_next  = used_reg;
        if (pop)
        begin
            idx_next   = '0;
            found_next = 1'b0;
        end
        if (state_reg == BK_CMP)
        begin
            if (match)
            begin
                found_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
        if (wr_en)
        begin
            count_next = count_reg + 1'b1;
            used_next  = used_reg + 33'(job_reg.region_bytes);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            idx_reg   <= '0;
            found_reg <= 1'b0;
            count_reg <= '0;
            used_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
            count_reg <= count_next;
            used_reg  <= used_next;
            done_reg  <= decide;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head_job;
        end
        if (decide)
        begin
            status_reg   <= status_calc;
            offset_reg   <= (status_calc == ST_NEW) ? base[31:0] : 32'd0;
            hash_out_reg <= job_reg.hash;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hash_mem[count_reg[AW-1:0]]   <= job_reg.hash;
            phys_mem[count_reg[AW-1:0]]   <= job_reg.phys_address;
            size_mem[count_reg[AW-1:0]]   <= job_reg.region_bytes;
            offset_mem[count_reg[AW-1:0]] <= base[31:0];
        end
        if (rd_en)
        begin
            rdata_reg <= hash_mem[idx_reg[AW-1:0]];
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign region_offset = offset_reg;
    assign name_hash     = hash_out_reg;

    a_done_after_decide : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == BK_DECIDE))
        else $error("result strobe without a decision");

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_C)
        else $error("entry count past table size");

    a_new_grows_count : assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> count_reg == $past(count_reg) + 1'b1)
        else $error("new entry did not advance the count");

    a_offset_only_new : assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != ST_NEW) |-> offset_reg == 32'd0)
        else $error("offset handed out on a failed request");

endmodule : nrra_back

`default_nettype wire

// ===== rtl/core/named_region_registry_allocator.sv =====
// Named region registry allocator. Name bytes are taken one per cycle
// while busy is low. A completed name waits in the queue until the back end
// pops it, walks the N entries in use (LOOK, CMP) and decides; done is then
// registered. Later names are taken meanwhile: up to two completed names
// wait in the queue; busy holds while it is full. The receiver cannot
// stall. Reset clears count, space and hash; table contents stay undefined.
// Depends on nrra_pkg, nrra_front/queue/back.
`default_nettype none

module named_region_registry_allocator
    import nrra_pkg::*;
#(
    parameter int MAX_ENTRIES = NRRA_MAX_ENTRIES_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [7:0]                name_byte,
    input  wire logic                      name_last,
    input  wire logic [63:0]               phys_address,
    input  wire logic [31:0]               region_bytes,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [NRRA_CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]               cfg_data,
    output logic                           done,
    output logic [1:0]                     status,
    output logic [31:0]                    region_offset,
    output logic [63:0]                    name_hash
);

    logic          cfg_write;
    logic [31:0]   device_reg;
    logic [15:0]   header_reg;
    logic          accept;
    logic          push;
    logic          pop;
    job_t          push_job;
    job_t          head_job;
    queue_status_t qstat;

    assign cfg_ready = 1'b1;
    assign busy      = qstat.full;
    assign accept    = start && !busy;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_reg <= NRRA_DEVICE_RESET;
            header_reg <= NRRA_HEADER_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DEVICE_BYTES: device_reg <= cfg_data;
                REG_HEADER_BYTES: header_reg <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    nrra_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .name_byte    (name_byte),
        .name_last    (name_last),
        .phys_address (phys_address),
        .region_bytes (region_bytes),
        .push         (push),
        .push_job     (push_job)
    );

    nrra_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .qstat    (qstat)
    );

    nrra_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_job      (head_job),
        .qstat         (qstat),
        .pop           (pop),
        .device_bytes  (device_reg),
        .header_bytes  (header_reg),
        .done          (done),
        .status        (status),
        .region_offset (region_offset),
        .name_hash     (name_hash)
    );

endmodule : named_region_registry_allocator

`default_nettype wire
